// ===== rtl/core/gbs_pkg.sv =====
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants of the greedy box suppression block.
// ----------------------------------------------------------------------------
`default_nettype none

package gbs_pkg;

  localparam int GBS_MAX_KEPT  = 64;
  localparam int GBS_MAX_BOXES = 4096;

  localparam int COORD_W = 12;
  localparam int SIZE_W  = 12;
  localparam int AREA_W  = 2 * SIZE_W;
  localparam int THR_W   = 9;
  localparam int INDEX_W = 12;
  localparam int TOTAL_W = 7;

  localparam logic [THR_W-1:0] GBS_THR_RESET = 9'd115;

  // Highest box index: saturates at the smaller of set size and field range
  localparam int IDX_MAX_INT = (GBS_MAX_BOXES - 1 < (1 << INDEX_W) - 1) ?
                               GBS_MAX_BOXES - 1 : (1 << INDEX_W) - 1;
  localparam logic [INDEX_W-1:0] GBS_IDX_MAX = INDEX_W'(IDX_MAX_INT);

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic [SIZE_W-1:0]         width;
    logic [SIZE_W-1:0]         height;
    logic [AREA_W-1:0]         area;
  } gbs_entry_t;

  typedef struct packed {
    logic busy;       // any comparison still in flight
    logic hit_valid;  // one comparison finished this cycle
    logic hit;        // overlap above the threshold
  } gbs_cmp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/gbs_table.sv =====
// ----------------------------------------------------------------------------
// gbs_table
// Store of kept boxes: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_table
  import gbs_pkg::*;
#(
  parameter int DEPTH = GBS_MAX_KEPT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire gbs_entry_t    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output gbs_entry_t         rd_data
);

  gbs_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gbs_iou_unit.sv =====
// ----------------------------------------------------------------------------
// gbs_iou_unit
// Pipelined overlap test of the current box against one stored box per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_iou_unit
  import gbs_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      kept_valid,
  input  wire gbs_entry_t                kept,
  input  wire logic signed [COORD_W-1:0] box_left,
  input  wire logic signed [COORD_W-1:0] box_top,
  input  wire logic [SIZE_W-1:0]         box_width,
  input  wire logic [SIZE_W-1:0]         box_height,
  input  wire logic [AREA_W-1:0]         box_area,
  input  wire logic [THR_W-1:0]          iou_threshold,
  output gbs_cmp_status_t                status
);

  localparam int EDGE_W = COORD_W + 2;
  localparam int UNI_W  = AREA_W + 1;
  localparam int LHS_W  = AREA_W + 8;
  localparam int RHS_W  = UNI_W + THR_W;

  logic signed [EDGE_W-1:0] ax_lo, ax_hi, bx_lo, bx_hi, x_lo, x_hi;
  logic signed [EDGE_W-1:0] ay_lo, ay_hi, by_lo, by_hi, y_lo, y_hi;
  logic [SIZE_W-1:0]        iw, ih;

  logic                     s1_valid_r, s2_valid_r, s3_valid_r, hit_valid_r, hit_r;
  logic [SIZE_W-1:0]        iw_r, ih_r;
  logic [AREA_W-1:0]        karea1_r, karea2_r;
  logic [AREA_W-1:0]        inter2_r, inter3_r;
  logic [UNI_W-1:0]         uni3_r;
  logic [LHS_W-1:0]         lhs;
  logic [RHS_W-1:0]         rhs;

  // Stage 1: intersection width and height
  always_comb begin
    ax_lo = EDGE_W'(box_left);
    ax_hi = ax_lo + $signed({2'b00, box_width});
    bx_lo = EDGE_W'(kept.left);
    bx_hi = bx_lo + $signed({2'b00, kept.width});
    ay_lo = EDGE_W'(box_top);
    ay_hi = ay_lo + $signed({2'b00, box_height});
    by_lo = EDGE_W'(kept.top);
    by_hi = by_lo + $signed({2'b00, kept.height});
    x_lo  = (ax_lo > bx_lo) ? ax_lo : bx_lo;
    x_hi  = (ax_hi < bx_hi) ? ax_hi : bx_hi;
    y_lo  = (ay_lo > by_lo) ? ay_lo : by_lo;
    y_hi  = (ay_hi < by_hi) ? ay_hi : by_hi;
    iw    = (x_hi > x_lo) ? SIZE_W'(x_hi - x_lo) : '0;
    ih    = (y_hi > y_lo) ? SIZE_W'(y_hi - y_lo) : '0;
  end

  // Stage 4: inter * 256 against threshold * union
  always_comb begin
    lhs = {inter3_r, 8'b0};
    rhs = RHS_W'(iou_threshold) * RHS_W'(uni3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      hit_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= kept_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      hit_valid_r <= s3_valid_r;
    end
    iw_r     <= iw;
    ih_r     <= ih;
    karea1_r <= kept.area;
    inter2_r <= AREA_W'(iw_r) * AREA_W'(ih_r);
    karea2_r <= karea1_r;
    uni3_r   <= UNI_W'(box_area) + UNI_W'(karea2_r) - UNI_W'(inter2_r);
    inter3_r <= inter2_r;
    hit_r    <= RHS_W'(lhs) > rhs;
  end

  assign status.busy      = s1_valid_r | s2_valid_r | s3_valid_r | hit_valid_r;
  assign status.hit_valid = hit_valid_r;
  assign status.hit       = hit_r;

endmodule

`default_nettype wire

// ===== rtl/core/greedy_box_suppression.sv =====
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Greedy non-maximum suppression of score-sorted boxes by overlap ratio.
// ----------------------------------------------------------------------------
// Boxes enter on the in_ channel (valid/stall), highest score first; a request
// with in_first_box set starts a new set. Each box is checked against every
// kept box of the set and gives one result on the out_ channel: keep flag,
// index in the set, running kept total and a table-full flag.
// A shared four-stage overlap unit takes one stored box per cycle from the box
// table, then drains. in_stall stays high from acceptance until the result is
// loaded into the output register, so one box is in work at a time and a new
// request is taken only after the previous box's result has been loaded.
// A finished result waits in the output register while out_stall is high;
// the next box may already be accepted and scanned, and its result is held
// until the register frees up.
// cfg_wr_en writes the overlap threshold (units of 1/256) and should only be
// pulsed while idle. Reset (rst_n low, synchronous) empties the set, zeroes
// the index counter and restores a threshold of 115. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_box_suppression
  import gbs_pkg::*;
#(
  parameter int MAX_KEPT = GBS_MAX_KEPT
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [THR_W-1:0]          cfg_wr_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [COORD_W-1:0] in_box_left,
  input  wire logic signed [COORD_W-1:0] in_box_top,
  input  wire logic [SIZE_W-1:0]         in_box_width,
  input  wire logic [SIZE_W-1:0]         in_box_height,
  input  wire logic                      in_first_box,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_keep,
  output logic [INDEX_W-1:0]             out_box_index,
  output logic [TOTAL_W-1:0]             out_kept_total,
  output logic                           out_table_full
);

  localparam int CW = $clog2(MAX_KEPT + 1);
  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t                    state_r;
  logic [THR_W-1:0]          thr_r;
  logic [CW-1:0]             count_r, scan_r;
  logic [INDEX_W-1:0]        index_r, my_index_r, start_index;
  logic signed [COORD_W-1:0] left_r, top_r;
  logic [SIZE_W-1:0]         width_r, height_r;
  logic [AREA_W-1:0]         area_r;
  logic                      suppress_r, rd_valid_r;
  logic                      accept, rd_en, out_free, has_room, store;
  gbs_entry_t                wr_entry, rd_entry;
  gbs_cmp_status_t           cmp_status;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid & ~in_stall;
  assign rd_en    = (state_r == ST_SCAN) && (scan_r < count_r);
  assign out_free = ~out_valid | ~out_stall;
  assign has_room = (count_r < CW'(MAX_KEPT));
  assign store    = (state_r == ST_FINISH) && out_free && !suppress_r && has_room;
  assign start_index = in_first_box ? '0 : index_r;

  assign wr_entry = '{left: left_r, top: top_r, width: width_r,
                      height: height_r, area: area_r};

  gbs_table #(
    .DEPTH (MAX_KEPT),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (scan_r[AW-1:0]),
    .rd_data (rd_entry)
  );

  gbs_iou_unit u_iou (
    .clk           (clk),
    .rst_n         (rst_n),
    .kept_valid    (rd_valid_r),
    .kept          (rd_entry),
    .box_left      (left_r),
    .box_top       (top_r),
    .box_width     (width_r),
    .box_height    (height_r),
    .box_area      (area_r),
    .iou_threshold (thr_r),
    .status        (cmp_status)
  );

  // Box area is ready well before the first union is formed
  always_ff @(posedge clk) begin
    area_r <= AREA_W'(width_r) * AREA_W'(height_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      thr_r      <= GBS_THR_RESET;
      count_r    <= '0;
      index_r    <= '0;
      scan_r     <= '0;
      rd_valid_r <= 1'b0;
      suppress_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      rd_valid_r <= rd_en;
      if ((state_r == ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        suppress_r <= 1'b0;
      end else if (cmp_status.hit_valid && cmp_status.hit) begin
        suppress_r <= 1'b1;
      end

      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            left_r     <= in_box_left;
            top_r      <= in_box_top;
            width_r    <= in_box_width;
            height_r   <= in_box_height;
            my_index_r <= start_index;
            index_r    <= (start_index < GBS_IDX_MAX) ? start_index + 1'b1 : start_index;
            if (in_first_box) begin
              count_r <= '0;
            end
            scan_r     <= '0;
            state_r    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            scan_r <= scan_r + 1'b1;
          end else begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // wait for the last comparison to be folded into suppress_r
          if (!rd_valid_r && !cmp_status.busy) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_keep       <= store;
            out_box_index  <= my_index_r;
            out_kept_total <= TOTAL_W'(store ? count_r + 1'b1 : count_r);
            out_table_full <= !suppress_r && !has_room;
            if (store) begin
              count_r <= count_r + 1'b1;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== test/greedy_box_suppression_tb.sv =====
// ----------------------------------------------------------------------------
// greedy_box_suppression_tb
// Drives box requests into the suppression block. Requests come with random
// gaps and the result side stalls at random, but for one steady phase. A model
// of the kept table predicts keep, index, kept total and table-full for every
// box, and each result is compared in order. Covered: boundary geometry,
// exact-threshold overlap, the threshold extremes, a full table, and clustered
// random sets at several thresholds.
// ----------------------------------------------------------------------------
module greedy_box_suppression_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gbs_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int THR_NEVER   = 256;  // no overlap can exceed this

  typedef struct {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic [SIZE_W-1:0]         width;
    logic [SIZE_W-1:0]         height;
    logic                      first;
  } box_req_t;

  typedef struct {
    logic               keep;
    logic [INDEX_W-1:0] index;
    logic [TOTAL_W-1:0] total;
    logic               full;
  } verdict_t;

  class keep_predictor;
    int       kept_left[GBS_MAX_KEPT];
    int       kept_top[GBS_MAX_KEPT];
    int       kept_width[GBS_MAX_KEPT];
    int       kept_height[GBS_MAX_KEPT];
    longint   kept_area[GBS_MAX_KEPT];
    int       kept_count;
    int       next_index;
    int       threshold;
    int       mismatches;
    verdict_t expected_verdicts[$];

    function new();
      kept_count = 0;
      next_index = 0;
      threshold  = GBS_THR_RESET;
      mismatches = 0;
    endfunction

    static function int span_overlap(int a0, int alen, int b0, int blen);
      int lo, hi;
      lo = (a0 > b0) ? a0 : b0;
      hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
      return (hi > lo) ? hi - lo : 0;
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    function void note_box(box_req_t b);
      int       l, t, w, h;
      longint   area, inter, uni;
      bit       survive;
      verdict_t v;
      l    = b.left;
      t    = b.top;
      w    = b.width;
      h    = b.height;
      area = longint'(w) * h;
      if (b.first) begin
        kept_count = 0;
        next_index = 0;
      end
      v.index = next_index[INDEX_W-1:0];
      if (next_index < GBS_IDX_MAX) next_index++;
      survive = 1'b1;
      for (int j = 0; j < kept_count; j++) begin
        inter = longint'(span_overlap(l, w, kept_left[j], kept_width[j])) *
                span_overlap(t, h, kept_top[j], kept_height[j]);
        uni = area + kept_area[j] - inter;
        if (inter * 256 > threshold * uni) survive = 1'b0;
      end
      v.keep = 1'b0;
      v.full = 1'b0;
      if (survive && kept_count < GBS_MAX_KEPT) begin
        kept_left[kept_count]   = l;
        kept_top[kept_count]    = t;
        kept_width[kept_count]  = w;
        kept_height[kept_count] = h;
        kept_area[kept_count]   = area;
        kept_count++;
        v.keep = 1'b1;
      end else if (survive) begin
        v.full = 1'b1;
      end
      v.total = kept_count[TOTAL_W-1:0];
      expected_verdicts = {expected_verdicts, v};
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        $error("result with no request pending: keep %0d index %0d", got.keep, got.index);
        mismatches++;
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.keep !== want.keep) begin
        $error("keep: expected %0d, got %0d", want.keep, got.keep);
        mismatches++;
      end
      if (got.index !== want.index) begin
        $error("box_index: expected %0d, got %0d", want.index, got.index);
        mismatches++;
      end
      if (got.total !== want.total) begin
        $error("kept_total: expected %0d, got %0d", want.total, got.total);
        mismatches++;
      end
      if (got.full !== want.full) begin
        $error("table_full: expected %0d, got %0d", want.full, got.full);
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [THR_W-1:0]          cfg_wr_data;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [COORD_W-1:0] in_box_left;
  logic signed [COORD_W-1:0] in_box_top;
  logic [SIZE_W-1:0]         in_box_width;
  logic [SIZE_W-1:0]         in_box_height;
  logic                      in_first_box;
  logic                      out_valid;
  logic                      out_stall;
  logic                      out_keep;
  logic [INDEX_W-1:0]        out_box_index;
  logic [TOTAL_W-1:0]        out_kept_total;
  logic                      out_table_full;

  bit            steady;
  int            quiet_cycles = 0;
  keep_predictor keep_calc = new();

  greedy_box_suppression uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_box_left   (in_box_left),
    .in_box_top    (in_box_top),
    .in_box_width  (in_box_width),
    .in_box_height (in_box_height),
    .in_first_box  (in_first_box),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_keep      (out_keep),
    .out_box_index (out_box_index),
    .out_kept_total(out_kept_total),
    .out_table_full(out_table_full)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 12);
  end

  always @(posedge clk) begin
    verdict_t got;
    box_req_t req;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.keep  = out_keep;
        got.index = out_box_index;
        got.total = out_kept_total;
        got.full  = out_table_full;
        keep_calc.check_verdict(got);
      end
      if (in_valid && !in_stall) begin
        req = '{in_box_left, in_box_top, in_box_width, in_box_height, in_first_box};
        keep_calc.note_box(req);
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  function automatic box_req_t make_box(int l, int t, int w, int h, bit first);
    box_req_t b;
    b.left   = COORD_W'(l);
    b.top    = COORD_W'(t);
    b.width  = SIZE_W'(w);
    b.height = SIZE_W'(h);
    b.first  = first;
    return b;
  endfunction

  function automatic box_req_t noise_box(bit first);
    return make_box($urandom_range(4095), $urandom_range(4095),
                    $urandom_range(4095), $urandom_range(4095), first);
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(span / 2)) - span / 4;
  endfunction

  task automatic send_box(box_req_t b);
    while (!steady && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_box_left   <= b.left;
    in_box_top    <= b.top;
    in_box_width  <= b.width;
    in_box_height <= b.height;
    in_first_box  <= b.first;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and hold until every request has its result back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (keep_calc.pending() != 0);
  endtask

  task automatic write_threshold(int value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= THR_W'(value);
    keep_calc.threshold = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Sets of boxes clustered around a few anchors, with some stray boxes.
  task automatic run_sets(int n_items);
    int       ax[4], ay[4], aw[4], ah[4];
    int       done, len, n_anchor, k;
    box_req_t b;
    done = 0;
    while (done < n_items) begin
      len      = ($urandom_range(7) == 0) ? $urandom_range(60, 90) : $urandom_range(2, 30);
      n_anchor = $urandom_range(1, 4);
      for (int a = 0; a < 4; a++) begin
        ax[a] = int'($urandom_range(3000)) - 1500;
        ay[a] = int'($urandom_range(3000)) - 1500;
        aw[a] = $urandom_range(4, 300);
        ah[a] = $urandom_range(4, 300);
      end
      for (int i = 0; i < len; i++) begin
        k = $urandom_range(n_anchor - 1);
        if ($urandom_range(99) < 15) b = noise_box(1'b0);
        else b = make_box(ax[k] + jitter(aw[k]), ay[k] + jitter(ah[k]),
                          aw[k] + jitter(aw[k]), ah[k] + jitter(ah[k]), 1'b0);
        // open each set; now and then restart one mid-stream
        b.first = (i == 0) || ($urandom_range(49) == 0);
        send_box(b);
      end
      done += len;
    end
  endtask

  initial begin
    int phase_thr[6];
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_valid      <= 1'b0;
    in_box_left   <= '0;
    in_box_top    <= '0;
    in_box_width  <= '0;
    in_box_height <= '0;
    in_first_box  <= 1'b0;
    out_stall     <= 1'b0;
    steady = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset threshold; the set after reset starts without a first flag
    send_box(make_box(-2048, -2048, 4095, 4095, 1'b0));
    send_box(make_box(-2048, -2048, 4095, 4095, 1'b0));
    send_box(make_box(2047, 2047, 4095, 4095, 1'b0));  // touches at a corner only
    send_box(make_box(0, 0, 0, 0, 1'b0));
    send_box(make_box(0, 0, 0, 0, 1'b0));              // empty against empty
    // overlap exactly at 115/256 survives, one column wider is suppressed
    send_box(make_box(0, 0, 16, 32, 1'b1));
    send_box(make_box(0, 0, 10, 23, 1'b0));
    send_box(make_box(0, 0, 11, 23, 1'b0));
    send_box(make_box(-10, -10, 10, 10, 1'b0));
    send_box(make_box(2047, -2048, 4095, 1, 1'b0));
    send_box(make_box(-1, -1, 4095, 4095, 1'b0));
    send_box(make_box(0, 0, 0, 4095, 1'b1));

    write_threshold(0);
    send_box(make_box(0, 0, 100, 100, 1'b1));
    send_box(make_box(99, 99, 10, 10, 1'b0));   // single shared pixel suppresses
    send_box(make_box(100, 0, 10, 10, 1'b0));

    write_threshold(THR_NEVER);
    send_box(make_box(5, 5, 50, 50, 1'b1));
    send_box(make_box(5, 5, 50, 50, 1'b0));
    send_box(make_box(5, 5, 50, 50, 1'b0));
    // overrun the kept table
    for (int i = 0; i < 70; i++) send_box(noise_box(i == 0));

    phase_thr = '{GBS_THR_RESET, 0, THR_NEVER, 64, 200, $urandom_range(1, 255)};
    foreach (phase_thr[p]) begin
      write_threshold(phase_thr[p]);
      steady = (p == 3);
      run_sets(80);
    end
    steady = 1'b0;

    drain();
    repeat (GBS_MAX_KEPT + 16) @(posedge clk);
    if (keep_calc.mismatches == 0 && keep_calc.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/gbs_pkg.sv
rtl/core/gbs_table.sv
rtl/core/gbs_iou_unit.sv
rtl/core/greedy_box_suppression.sv
test/greedy_box_suppression_tb.sv
